### sv/assert_macros.svh
// Assertion macros used by the checker file of the touch point calibration block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tpc_pkg.sv
// Shared types and constants of the touch point calibration pipeline.
package tpc_pkg;

  localparam int RAW_W   = 12;
  localparam int PRESS_W = 13;
  localparam int DIFF_W  = 13;
  localparam int SQ_W    = 24;
  localparam int NUM_W   = 24;
  localparam int QUO_W   = 12;
  localparam int CFG_IDX_W = 4;

  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = QUO_W / DIV_STEPS;

  localparam logic [RAW_W-1:0] RAW_FULL = 12'd4095;

  localparam int ORIENT_SWAP  = 0;
  localparam int ORIENT_INV_X = 1;
  localparam int ORIENT_INV_Y = 2;

  localparam logic [RAW_W-1:0] CAL_LOW_RST  = 12'd200;
  localparam logic [RAW_W-1:0] CAL_HIGH_RST = 12'd3900;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAL_X_LOW      = 4'd0,
    CFG_CAL_X_HIGH     = 4'd1,
    CFG_CAL_Y_LOW      = 4'd2,
    CFG_CAL_Y_HIGH     = 4'd3,
    CFG_ORIENTATION    = 4'd4,
    CFG_GHOST_CENTER_X = 4'd5,
    CFG_GHOST_CENTER_Y = 4'd6,
    CFG_GHOST_RADIUS   = 4'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CLAMP_LOW  = 2'b00,
    CLAMP_HIGH = 2'b01,
    CLAMP_MID  = 2'b10
  } clamp_e;

  typedef struct packed {
    logic [RAW_W-1:0] cal_x_low;
    logic [RAW_W-1:0] cal_x_high;
    logic [RAW_W-1:0] cal_y_low;
    logic [RAW_W-1:0] cal_y_high;
    logic [2:0]       orientation;
    logic [RAW_W-1:0] ghost_center_x;
    logic [RAW_W-1:0] ghost_center_y;
    logic [RAW_W-1:0] ghost_radius;
  } cfg_t;

  // Front end output: averaged point and ghost circle squares.
  typedef struct packed {
    logic             touch;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
    logic [SQ_W-1:0]  sq_x;
    logic [SQ_W-1:0]  sq_y;
    logic [SQ_W-1:0]  r2;
  } front_t;

  // One axis in flight through the restoring divider.
  typedef struct packed {
    clamp_e           sel;
    logic [RAW_W-1:0] rem;
    logic [RAW_W-1:0] nlo;
    logic [RAW_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } axis_div_t;

  typedef struct packed {
    logic      touch;
    axis_div_t ax;
    axis_div_t ay;
  } div_bundle_t;

endpackage

### sv/touch_point_calibrate_top.sv
// Touch point calibration: raw touch measurement in, screen pixel out.
//
// Input channel (in_valid_i / in_ready_o) carries one measurement per beat:
// two pressure readings and four samples per axis. Output channel
// (out_valid_o / out_ready_i) returns exactly one result beat per input beat,
// in order: touched_o, pixel_x_o, pixel_y_o (pixels are zero when not touched).
// Configuration channel (cfg_valid_i / cfg_ready_o) writes register
// cfg_index_i with cfg_data_i; it is always ready. Write it only while idle.
// Throughput: one beat per cycle unless the receiver stalls. Depth: eight register stages;
// the depth comes from the 12-bit restoring divider, cut into four stages of 3 quotient
// bits each, behind three front stages (average, squares, clamp and scale).
// Each stage holds a valid bit and moves whenever the next one is free, so
// bubbles collapse; when the receiver stalls, the pipeline fills and then
// deasserts in_ready_o, with nothing lost or repeated.
// Reset clears all valid bits and loads the calibration defaults.
module touch_point_calibrate_top
  import tpc_pkg::*;
#(
  parameter int SCREEN_WIDTH       = 320,
  parameter int SCREEN_HEIGHT      = 240,
  parameter int PRESSURE_THRESHOLD = 400
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [RAW_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [RAW_W-1:0]     press_one_i,
  input  logic [RAW_W-1:0]     press_two_i,
  input  logic [RAW_W-1:0]     x_sample_a_i,
  input  logic [RAW_W-1:0]     x_sample_b_i,
  input  logic [RAW_W-1:0]     x_sample_c_i,
  input  logic [RAW_W-1:0]     x_sample_d_i,
  input  logic [RAW_W-1:0]     y_sample_a_i,
  input  logic [RAW_W-1:0]     y_sample_b_i,
  input  logic [RAW_W-1:0]     y_sample_c_i,
  input  logic [RAW_W-1:0]     y_sample_d_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 touched_o,
  output logic [8:0]           pixel_x_o,
  output logic [7:0]           pixel_y_o
);

  localparam int NSTG = DIV_STAGES + 4;
  localparam int OUT  = NSTG - 1;
  localparam logic [QUO_W-1:0] TOP_X = QUO_W'(SCREEN_WIDTH - 1);
  localparam logic [QUO_W-1:0] TOP_Y = QUO_W'(SCREEN_HEIGHT - 1);

  cfg_t              cfg;
  logic [NSTG-1:0]   v_q;
  logic [NSTG-1:0]   en;
  front_t            front;
  div_bundle_t       div_b [DIV_STAGES+1];

  logic              touched_d, touched_q;
  logic [8:0]        pixel_x_d, pixel_x_q;
  logic [7:0]        pixel_y_d, pixel_y_q;
  logic [QUO_W-1:0]  px, py;

  assign cfg_ready_o = 1'b1;

  tpc_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_valid_i (cfg_valid_i & cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o       (cfg)
  );

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    en[OUT] = !v_q[OUT] || out_ready_i;
    for (int k = OUT - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  tpc_front #(
    .PRESSURE_THRESHOLD (PRESSURE_THRESHOLD)
  ) u_front (
    .clk_i,
    .en_i    (en[1:0]),
    .cfg_i   (cfg),
    .press_one_i,
    .press_two_i,
    .x_sample_a_i,
    .x_sample_b_i,
    .x_sample_c_i,
    .x_sample_d_i,
    .y_sample_a_i,
    .y_sample_b_i,
    .y_sample_c_i,
    .y_sample_d_i,
    .front_o (front)
  );

  tpc_map_prep #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_prep (
    .clk_i,
    .en_i     (en[2]),
    .cfg_i    (cfg),
    .front_i  (front),
    .bundle_o (div_b[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    tpc_div_stage u_div (
      .clk_i,
      .en_i     (en[3+g]),
      .bundle_i (div_b[g]),
      .bundle_o (div_b[g+1])
    );
  end

  function automatic logic [QUO_W-1:0] pick(axis_div_t a, logic [QUO_W-1:0] top);
    logic [QUO_W-1:0] p;
    case (a.sel)
      CLAMP_LOW:  p = '0;
      CLAMP_HIGH: p = top;
      default:    p = a.quo;
    endcase
    return p;
  endfunction

  // Invert after mapping, then mask to the field widths.
  always_comb begin
    px = pick(div_b[DIV_STAGES].ax, TOP_X);
    py = pick(div_b[DIV_STAGES].ay, TOP_Y);
    if (cfg.orientation[ORIENT_INV_X]) px = TOP_X - px;
    if (cfg.orientation[ORIENT_INV_Y]) py = TOP_Y - py;
    touched_d = div_b[DIV_STAGES].touch;
    pixel_x_d = touched_d ? px[8:0] : '0;
    pixel_y_d = touched_d ? py[7:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[OUT]) begin
      touched_q <= touched_d;
      pixel_x_q <= pixel_x_d;
      pixel_y_q <= pixel_y_d;
    end
  end

  assign out_valid_o = v_q[OUT];
  assign touched_o   = touched_q;
  assign pixel_x_o   = pixel_x_q;
  assign pixel_y_o   = pixel_y_q;

endmodule

### sv/tpc_cfg_regs.sv
// Configuration register file of the touch point calibration block.
module tpc_cfg_regs
  import tpc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [RAW_W-1:0]     cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cal_x_low      <= CAL_LOW_RST;
      cfg_q.cal_x_high     <= CAL_HIGH_RST;
      cfg_q.cal_y_low      <= CAL_LOW_RST;
      cfg_q.cal_y_high     <= CAL_HIGH_RST;
      cfg_q.orientation    <= '0;
      cfg_q.ghost_center_x <= '0;
      cfg_q.ghost_center_y <= '0;
      cfg_q.ghost_radius   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CAL_X_LOW:      cfg_q.cal_x_low      <= cfg_data_i;
        CFG_CAL_X_HIGH:     cfg_q.cal_x_high     <= cfg_data_i;
        CFG_CAL_Y_LOW:      cfg_q.cal_y_low      <= cfg_data_i;
        CFG_CAL_Y_HIGH:     cfg_q.cal_y_high     <= cfg_data_i;
        CFG_ORIENTATION:    cfg_q.orientation    <= cfg_data_i[2:0];
        CFG_GHOST_CENTER_X: cfg_q.ghost_center_x <= cfg_data_i;
        CFG_GHOST_CENTER_Y: cfg_q.ghost_center_y <= cfg_data_i;
        CFG_GHOST_RADIUS:   cfg_q.ghost_radius   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/tpc_front.sv
// Front stages: pressure gate, axis averages, ghost circle distances and squares.
module tpc_front
  import tpc_pkg::*;
#(
  parameter int PRESSURE_THRESHOLD = 400
) (
  input  logic             clk_i,
  input  logic [1:0]       en_i,
  input  cfg_t             cfg_i,
  input  logic [RAW_W-1:0] press_one_i,
  input  logic [RAW_W-1:0] press_two_i,
  input  logic [RAW_W-1:0] x_sample_a_i,
  input  logic [RAW_W-1:0] x_sample_b_i,
  input  logic [RAW_W-1:0] x_sample_c_i,
  input  logic [RAW_W-1:0] x_sample_d_i,
  input  logic [RAW_W-1:0] y_sample_a_i,
  input  logic [RAW_W-1:0] y_sample_b_i,
  input  logic [RAW_W-1:0] y_sample_c_i,
  input  logic [RAW_W-1:0] y_sample_d_i,
  output front_t           front_o
);

  localparam logic [PRESS_W-1:0] THRESH = PRESS_W'(PRESSURE_THRESHOLD);

  logic [PRESS_W-1:0]       press;
  logic [RAW_W+1:0]         sum_x, sum_y;
  logic                     touch_d, touch_q;
  logic [RAW_W-1:0]         raw_x_d, raw_x_q, raw_y_d, raw_y_q;
  logic signed [DIFF_W-1:0] dx_d, dx_q, dy_d, dy_q;
  logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;
  front_t                   front_d, front_q;

  // press_one + 4095 - press_two never goes negative.
  always_comb begin
    press   = {1'b0, press_one_i} + {1'b0, RAW_FULL} - {1'b0, press_two_i};
    touch_d = (press >= THRESH);
    sum_x   = {2'b0, x_sample_a_i} + {2'b0, x_sample_b_i}
            + {2'b0, x_sample_c_i} + {2'b0, x_sample_d_i};
    sum_y   = {2'b0, y_sample_a_i} + {2'b0, y_sample_b_i}
            + {2'b0, y_sample_c_i} + {2'b0, y_sample_d_i};
    raw_x_d = sum_x[RAW_W+1:2];
    raw_y_d = sum_y[RAW_W+1:2];
    dx_d    = $signed({1'b0, raw_x_d}) - $signed({1'b0, cfg_i.ghost_center_x});
    dy_d    = $signed({1'b0, raw_y_d}) - $signed({1'b0, cfg_i.ghost_center_y});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      touch_q <= touch_d;
      raw_x_q <= raw_x_d;
      raw_y_q <= raw_y_d;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
    end
  end

  always_comb begin
    sqx_full      = dx_q * dx_q;
    sqy_full      = dy_q * dy_q;
    front_d.touch = touch_q;
    front_d.raw_x = raw_x_q;
    front_d.raw_y = raw_y_q;
    front_d.sq_x  = sqx_full[SQ_W-1:0];
    front_d.sq_y  = sqy_full[SQ_W-1:0];
    front_d.r2    = cfg_i.ghost_radius * cfg_i.ghost_radius;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

### sv/tpc_map_prep.sv
// Ghost rejection, axis swap, clamp decision and scaled numerator per axis.
module tpc_map_prep
  import tpc_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  cfg_t        cfg_i,
  input  front_t      front_i,
  output div_bundle_t bundle_o
);

  localparam logic [QUO_W-1:0] TOP_X = QUO_W'(SCREEN_WIDTH - 1);
  localparam logic [QUO_W-1:0] TOP_Y = QUO_W'(SCREEN_HEIGHT - 1);

  function automatic axis_div_t prep_axis(logic [RAW_W-1:0] raw, logic [RAW_W-1:0] lo,
                                          logic [RAW_W-1:0] hi, logic [QUO_W-1:0] top);
    axis_div_t        a;
    logic [RAW_W-1:0] off;
    logic [NUM_W-1:0] num;
    off = raw - lo;
    num = off * top;
    if (raw <= lo) begin
      a.sel = CLAMP_LOW;
    end else if (raw >= hi) begin
      a.sel = CLAMP_HIGH;
    end else begin
      a.sel = CLAMP_MID;
    end
    // Quotient stays below top, so the upper half is already below den.
    a.rem = num[NUM_W-1:QUO_W];
    a.nlo = num[QUO_W-1:0];
    a.den = hi - lo;
    a.quo = '0;
    return a;
  endfunction

  logic             reject;
  logic [RAW_W-1:0] mx, my, xlo, xhi, ylo, yhi;
  div_bundle_t      bundle_d, bundle_q;

  always_comb begin
    reject = (cfg_i.ghost_radius != '0) &&
             (({1'b0, front_i.sq_x} + {1'b0, front_i.sq_y}) < {1'b0, front_i.r2});
    if (cfg_i.orientation[ORIENT_SWAP]) begin
      mx  = front_i.raw_y;     my  = front_i.raw_x;
      xlo = cfg_i.cal_y_low;   xhi = cfg_i.cal_y_high;
      ylo = cfg_i.cal_x_low;   yhi = cfg_i.cal_x_high;
    end else begin
      mx  = front_i.raw_x;     my  = front_i.raw_y;
      xlo = cfg_i.cal_x_low;   xhi = cfg_i.cal_x_high;
      ylo = cfg_i.cal_y_low;   yhi = cfg_i.cal_y_high;
    end
    bundle_d.touch = front_i.touch && !reject;
    bundle_d.ax    = prep_axis(mx, xlo, xhi, TOP_X);
    bundle_d.ay    = prep_axis(my, ylo, yhi, TOP_Y);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bundle_q <= bundle_d;
    end
  end

  assign bundle_o = bundle_q;

endmodule

### sv/tpc_div_stage.sv
// One registered slice of the restoring divider, three quotient bits per axis.
module tpc_div_stage
  import tpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  div_bundle_t bundle_i,
  output div_bundle_t bundle_o
);

  function automatic axis_div_t div_steps(axis_div_t a_in);
    axis_div_t      a;
    logic [RAW_W:0] t;
    a = a_in;
    for (int s = 0; s < DIV_STEPS; s++) begin
      t     = {a.rem, a.nlo[QUO_W-1]};
      a.nlo = {a.nlo[QUO_W-2:0], 1'b0};
      if (t >= {1'b0, a.den}) begin
        a.rem = RAW_W'(t - {1'b0, a.den});
        a.quo = {a.quo[QUO_W-2:0], 1'b1};
      end else begin
        a.rem = t[RAW_W-1:0];
        a.quo = {a.quo[QUO_W-2:0], 1'b0};
      end
    end
    return a;
  endfunction

  div_bundle_t bundle_d, bundle_q;

  always_comb begin
    bundle_d.touch = bundle_i.touch;
    bundle_d.ax    = div_steps(bundle_i.ax);
    bundle_d.ay    = div_steps(bundle_i.ay);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bundle_q <= bundle_d;
    end
  end

  assign bundle_o = bundle_q;

endmodule

### sv/tpc_checker.sv
// Port-level checker of the touch point calibration block and its bind.
`include "assert_macros.svh"

module tpc_checker #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       touched_o,
  input logic [8:0] pixel_x_o,
  input logic [7:0] pixel_y_o
);

  // A rejected or untouched beat carries zero pixels.
  `ASSERT_IMPL(a_untouched_zero, clk_i, rst_ni, out_valid_o && !touched_o,
               pixel_x_o == '0 && pixel_y_o == '0, "untouched result with nonzero pixel")

  // Pixels never leave the screen when the field holds the whole range.
  `ASSERT_IMPL(a_pixel_range, clk_i, rst_ni, out_valid_o && touched_o,
               (SCREEN_WIDTH > 512 || pixel_x_o < SCREEN_WIDTH) &&
               (SCREEN_HEIGHT > 256 || pixel_y_o < SCREEN_HEIGHT),
               "pixel outside the screen")

  `ASSERT_IMPL(a_cfg_ready, clk_i, rst_ni, 1'b1, cfg_ready_o, "config port not ready")

  // Hold a stalled result beat.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
               out_valid_o && $stable(touched_o) && $stable(pixel_x_o) && $stable(pixel_y_o),
               "stalled result beat changed")

endmodule

bind touch_point_calibrate_top tpc_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tpc_checker (.*);
